### hw/rtl/llpe_pkg.sv
package llpe_pkg;

  localparam int STEP_X_LOG2 = 2;
  localparam int STEP_Y_LOG2 = 2;
  localparam int STEP_X      = 1 << STEP_X_LOG2;
  localparam int STEP_Y      = 1 << STEP_Y_LOG2;
  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 2048;
  localparam int COL_LIMIT   = (MAX_WIDTH  < 2048) ? MAX_WIDTH  : 2048;
  localparam int ROW_LIMIT   = (MAX_HEIGHT < 2048) ? MAX_HEIGHT : 2048;

  localparam int PIX_W   = 8;
  localparam int COL_W   = 11;
  localparam int ROW_W   = 11;
  localparam int SROW_W  = 9;
  localparam int COEF_W  = 16;
  localparam int DIFF_W  = COL_W + 1;
  localparam int PROD_W  = DIFF_W + COEF_W;
  localparam int GRID_W  = 12;
  localparam int FRAC_W  = 15;
  localparam int CFG_A_W = 2;

  localparam logic [COL_W-1:0] COL_MAX  = COL_W'(COL_LIMIT - 1);
  localparam logic [ROW_W-1:0] ROW_MAX  = ROW_W'(ROW_LIMIT - 1);
  localparam logic [ROW_W-1:0] ROW_MASK = ROW_W'(STEP_Y - 1);
  localparam logic [GRID_W-1:0] GX_KEEP = ~GRID_W'(STEP_X - 1);
  localparam logic [GRID_W-1:0] GY_KEEP = ~GRID_W'(STEP_Y - 1);
  localparam logic signed [PROD_W-1:0] TRUNC_BIAS = PROD_W'((1 << FRAC_W) - 1);

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [GRID_W-1:0] grid_t;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_COS_ANGLE   = 2'd0,
    CFG_SIN_ANGLE   = 2'd1,
    CFG_MIDDLE_COL  = 2'd2,
    CFG_BRIGHT_THR  = 2'd3
  } cfg_idx_t;

endpackage

### hw/rtl/laser_line_profile_extractor.sv
// Laser line profile extractor.
// Input channel (in_*): one RGB pixel per transfer in raster order, with
// in_start_of_frame on the first pixel of an image and in_end_of_row on the
// last pixel of each row. Every fourth row is searched for its first pixel
// whose red, green and blue all exceed the threshold.
// Result channel (out_*): one transfer per searched row, carrying the index
// of the searched row, the found flag and the rotated point floored to the grid.
// Config channel (cfg_*): always ready; write only while no results pend.
// Throughput: one pixel per cycle while out_ready is high. A row result
// passes the offset register, the multiplier register and the result
// register before it appears on out_valid; a stall can hold it in any of them.
// Stall: the three stages advance together; while a result waits with
// out_ready low, in_ready is low and nothing moves.
// Reset: rst_n (synchronous, active low) clears counters and valids and
// loads the register defaults (cos 32767, sin 0, middle 1024, threshold 70).
module laser_line_profile_extractor (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [llpe_pkg::PIX_W-1:0]          in_red,
  input  logic [llpe_pkg::PIX_W-1:0]          in_green,
  input  logic [llpe_pkg::PIX_W-1:0]          in_blue,
  input  logic                                in_end_of_row,
  input  logic                                in_start_of_frame,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [llpe_pkg::SROW_W-1:0]         out_row_index,
  output logic signed [llpe_pkg::GRID_W-1:0]  out_grid_x,
  output logic signed [llpe_pkg::GRID_W-1:0]  out_grid_y,
  output logic                                out_found,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [llpe_pkg::CFG_A_W-1:0]        cfg_index,
  input  logic [llpe_pkg::COEF_W-1:0]         cfg_data
);

  llpe_pkg::coef_t                  cos_r, sin_r;
  logic [llpe_pkg::COL_W-1:0]       middle_r;
  logic [llpe_pkg::PIX_W-1:0]       thr_r;

  logic [llpe_pkg::COL_W-1:0]       col_r, col_nxt, hit_col_r, hit_col_nxt;
  logic [llpe_pkg::ROW_W-1:0]       row_r, row_nxt;
  logic [llpe_pkg::SROW_W-1:0]      srow_r, srow_nxt;
  logic                             hit_seen_r, hit_seen_nxt;

  logic [llpe_pkg::COL_W-1:0]       col_base;
  logic [llpe_pkg::ROW_W-1:0]       row_base;
  logic [llpe_pkg::SROW_W-1:0]      srow_base;
  logic                             hit_base, sampled, bright, hit_now, emit;
  logic                             advance, in_xfer;

  logic                             s1_valid_r, s2_valid_r, out_valid_r;
  llpe_pkg::diff_t                  s1_diff_r;
  logic [llpe_pkg::SROW_W-1:0]      s1_row_r, s2_row_r, out_row_r;
  logic                             s1_found_r, s2_found_r, out_found_r;
  llpe_pkg::prod_t                  s2_px_r, s2_py_r;
  llpe_pkg::prod_t                  px_bias, py_bias;
  llpe_pkg::grid_t                  vx, vy, gx_r, gy_r;
  llpe_pkg::diff_t                  diff_nxt;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = advance;
  assign in_xfer   = in_valid && in_ready;

  // pixel bookkeeping
  always_comb begin
    col_base  = in_start_of_frame ? '0 : col_r;
    row_base  = in_start_of_frame ? '0 : row_r;
    srow_base = in_start_of_frame ? '0 : srow_r;
    hit_base  = in_start_of_frame ? 1'b0 : hit_seen_r;
    sampled   = (row_base & llpe_pkg::ROW_MASK) == '0;
    bright    = (in_red > thr_r) && (in_green > thr_r) && (in_blue > thr_r);
    hit_now   = sampled && !hit_base && bright;
    hit_seen_nxt = hit_base || hit_now;
    hit_col_nxt  = hit_now ? col_base : hit_col_r;
    emit      = in_end_of_row && sampled;
    diff_nxt  = hit_seen_nxt ?
                $signed({1'b0, middle_r}) - $signed({1'b0, hit_col_nxt}) : '0;
    col_nxt   = col_base;
    row_nxt   = row_base;
    srow_nxt  = srow_base;
    if (!in_end_of_row) begin
      if (col_base < llpe_pkg::COL_MAX) begin
        col_nxt = col_base + 1'b1;
      end
    end else begin
      col_nxt = '0;
      row_nxt = (row_base >= llpe_pkg::ROW_MAX) ? '0 : row_base + 1'b1;
      if (sampled) begin
        srow_nxt = srow_base + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      srow_r     <= '0;
      hit_seen_r <= 1'b0;
      hit_col_r  <= '0;
    end else if (in_xfer) begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      srow_r     <= srow_nxt;
      hit_seen_r <= in_end_of_row ? 1'b0 : hit_seen_nxt;
      hit_col_r  <= hit_col_nxt;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r    <= 16'sd32767;
      sin_r    <= '0;
      middle_r <= 11'd1024;
      thr_r    <= 8'd70;
    end else if (cfg_valid && cfg_ready) begin
      case (llpe_pkg::cfg_idx_t'(cfg_index))
        llpe_pkg::CFG_COS_ANGLE:  cos_r    <= cfg_data;
        llpe_pkg::CFG_SIN_ANGLE:  sin_r    <= cfg_data;
        llpe_pkg::CFG_MIDDLE_COL: middle_r <= cfg_data[llpe_pkg::COL_W-1:0];
        llpe_pkg::CFG_BRIGHT_THR: thr_r    <= cfg_data[llpe_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // result pipeline
  always_comb begin
    px_bias = s2_px_r + (s2_px_r[llpe_pkg::PROD_W-1] ? llpe_pkg::TRUNC_BIAS : '0);
    py_bias = s2_py_r + (s2_py_r[llpe_pkg::PROD_W-1] ? llpe_pkg::TRUNC_BIAS : '0);
    vx = px_bias[llpe_pkg::FRAC_W +: llpe_pkg::GRID_W];
    vy = py_bias[llpe_pkg::FRAC_W +: llpe_pkg::GRID_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= in_xfer && emit;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_diff_r   <= diff_nxt;
      s1_row_r    <= srow_base;
      s1_found_r  <= hit_seen_nxt;
      s2_px_r     <= s1_diff_r * cos_r;
      s2_py_r     <= s1_diff_r * sin_r;
      s2_row_r    <= s1_row_r;
      s2_found_r  <= s1_found_r;
      gx_r        <= vx & llpe_pkg::GX_KEEP;
      gy_r        <= vy & llpe_pkg::GY_KEEP;
      out_row_r   <= s2_row_r;
      out_found_r <= s2_found_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_r;
  assign out_grid_x    = gx_r;
  assign out_grid_y    = gy_r;
  assign out_found     = out_found_r;

endmodule

### test/laser_line_profile_extractor_tb.sv
`timescale 1ns / 1ps

module laser_line_profile_extractor_tb;
  import llpe_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             eor;
    logic             sof;
  } pixel_t;

  typedef struct packed {
    logic [SROW_W-1:0] row_index;
    grid_t             grid_x;
    grid_t             grid_y;
    logic              found;
  } row_result_t;

  typedef enum int {PIX_ANY, PIX_DARK, PIX_BRIGHT, PIX_EDGE} pix_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PIX_W-1:0] in_red = '0;
  logic [PIX_W-1:0] in_green = '0;
  logic [PIX_W-1:0] in_blue = '0;
  logic in_end_of_row = 1'b0;
  logic in_start_of_frame = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SROW_W-1:0] out_row_index;
  logic signed [GRID_W-1:0] out_grid_x;
  logic signed [GRID_W-1:0] out_grid_y;
  logic out_found;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_A_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;

  pixel_t      pending_pixels[$];
  row_result_t expected_rows[$];

  logic pixel_taken = 1'b0;
  logic cfg_taken = 1'b0;
  int   in_idle_pct = 0;
  int   out_idle_pct = 0;
  int   gen_thr = 70;
  int   mismatch_count = 0;
  int   stall_cycles = 0;

  // shadow of the block's registers and row state
  coef_t            cos_q;
  coef_t            sin_q;
  logic [COL_W-1:0] mid_q;
  logic [PIX_W-1:0] thr_q;
  int               col_cnt;
  int               row_cnt;
  int               srow_cnt;
  logic             hit_seen;
  int               hit_col;

  laser_line_profile_extractor DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .in_end_of_row     (in_end_of_row),
    .in_start_of_frame (in_start_of_frame),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_row_index     (out_row_index),
    .out_grid_x        (out_grid_x),
    .out_grid_y        (out_grid_y),
    .out_found         (out_found),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic reset_model();
    cos_q    = 16'sd32767;
    sin_q    = '0;
    mid_q    = 11'd1024;
    thr_q    = 8'd70;
    col_cnt  = 0;
    row_cnt  = 0;
    srow_cnt = 0;
    hit_seen = 1'b0;
    hit_col  = 0;
  endtask

  // d * coef / 2^15 truncated toward zero, floored to the grid step, clamped to -2048..2047
  function automatic grid_t rotate_to_grid(int d, int coef, int step);
    int p;
    int v;
    int q;
    p = d * coef;
    v = p / 32768;
    q = v / step;
    if (v % step < 0) q = q - 1;
    q = q * step;
    if (q < -2048) q = -2048;
    if (q > 2047) q = 2047;
    return grid_t'(q);
  endfunction

  task automatic track_line_pixel(pixel_t px);
    logic        sampled;
    row_result_t res;
    int          d;
    if (px.sof) begin
      col_cnt  = 0;
      row_cnt  = 0;
      srow_cnt = 0;
      hit_seen = 1'b0;
    end
    sampled = (row_cnt % STEP_Y) == 0;
    if (sampled && !hit_seen && px.red > thr_q && px.green > thr_q && px.blue > thr_q) begin
      hit_seen = 1'b1;
      hit_col  = col_cnt;
    end
    if (!px.eor) begin
      if (col_cnt < COL_LIMIT - 1) col_cnt++;
    end else begin
      if (sampled) begin
        res.row_index = SROW_W'(srow_cnt);
        res.found     = hit_seen;
        res.grid_x    = '0;
        res.grid_y    = '0;
        if (hit_seen) begin
          d = int'(mid_q) - hit_col;
          res.grid_x = rotate_to_grid(d, int'(cos_q), STEP_X);
          res.grid_y = rotate_to_grid(d, int'(sin_q), STEP_Y);
        end
        expected_rows.push_back(res);
        srow_cnt = (srow_cnt + 1) % (1 << SROW_W);
      end
      col_cnt  = 0;
      hit_seen = 1'b0;
      row_cnt++;
      if (row_cnt >= ROW_LIMIT) row_cnt = 0;
    end
  endtask

  task automatic apply_reg(logic [CFG_A_W-1:0] idx, logic [COEF_W-1:0] data);
    case (cfg_idx_t'(idx))
      CFG_COS_ANGLE:  cos_q = coef_t'(data);
      CFG_SIN_ANGLE:  sin_q = coef_t'(data);
      CFG_MIDDLE_COL: mid_q = data[COL_W-1:0];
      CFG_BRIGHT_THR: thr_q = data[PIX_W-1:0];
      default: ;
    endcase
  endtask

  // monitor: transfers, prediction, checking, watchdog
  always @(posedge clk) begin : monitor
    row_result_t want;
    if (!rst_n) begin
      pixel_taken <= 1'b0;
      cfg_taken   <= 1'b0;
    end else begin
      pixel_taken <= in_valid && in_ready;
      cfg_taken   <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready)
        track_line_pixel({in_red, in_green, in_blue, in_end_of_row, in_start_of_frame});
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          report_mismatch($sformatf("unexpected result row_index=%0d", out_row_index));
        end else begin
          want = expected_rows.pop_front();
          if (out_row_index !== want.row_index)
            report_mismatch($sformatf("row_index got %0d exp %0d", out_row_index,
                                      want.row_index));
          if (out_grid_x !== want.grid_x)
            report_mismatch($sformatf("row %0d grid_x got %0d exp %0d", want.row_index,
                                      out_grid_x, want.grid_x));
          if (out_grid_y !== want.grid_y)
            report_mismatch($sformatf("row %0d grid_y got %0d exp %0d", want.row_index,
                                      out_grid_y, want.grid_y));
          if (out_found !== want.found)
            report_mismatch($sformatf("row %0d found got %b exp %b", want.row_index,
                                      out_found, want.found));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", stall_cycles);
        $display("Test completed with failures");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // driver: pixel channel and result back-pressure
  always @(negedge clk) begin : driver
    pixel_t px;
    if (!in_valid || pixel_taken) begin
      if (pending_pixels.size() != 0 && $urandom_range(99, 0) >= in_idle_pct) begin
        px = pending_pixels.pop_front();
        in_valid          <= 1'b1;
        in_red            <= px.red;
        in_green          <= px.green;
        in_blue           <= px.blue;
        in_end_of_row     <= px.eor;
        in_start_of_frame <= px.sof;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99, 0) >= out_idle_pct);
  end

  function automatic pixel_t make_pixel(pix_kind_t kind);
    pixel_t px;
    int     k;
    px.red   = PIX_W'($urandom_range(255, 0));
    px.green = PIX_W'($urandom_range(255, 0));
    px.blue  = PIX_W'($urandom_range(255, 0));
    px.eor   = 1'b0;
    px.sof   = 1'b0;
    case (kind)
      PIX_BRIGHT: begin
        if (gen_thr >= 255) begin
          px.red   = 8'hFF;
          px.green = 8'hFF;
          px.blue  = 8'hFF;
        end else begin
          px.red   = PIX_W'($urandom_range(255, gen_thr + 1));
          px.green = PIX_W'($urandom_range(255, gen_thr + 1));
          px.blue  = PIX_W'($urandom_range(255, gen_thr + 1));
        end
      end
      PIX_DARK: begin
        k = $urandom_range(2, 0);
        if (k == 0) px.red = PIX_W'($urandom_range(gen_thr, 0));
        else if (k == 1) px.green = PIX_W'($urandom_range(gen_thr, 0));
        else px.blue = PIX_W'($urandom_range(gen_thr, 0));
      end
      PIX_EDGE: begin
        px.red   = (gen_thr >= 255) ? 8'hFF : PIX_W'(gen_thr + $urandom_range(1, 0));
        px.green = (gen_thr >= 255) ? 8'hFF : PIX_W'(gen_thr + $urandom_range(1, 0));
        px.blue  = (gen_thr >= 255) ? 8'hFF : PIX_W'(gen_thr + $urandom_range(1, 0));
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic push_pixel(int r, int g, int b, bit eor, bit sof);
    pending_pixels.push_back({PIX_W'(r), PIX_W'(g), PIX_W'(b), eor, sof});
  endtask

  task automatic push_row(int len, int bright_pct, bit sof_first);
    pixel_t    px;
    pix_kind_t kind;
    int        roll;
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(99, 0);
      if (roll < bright_pct) kind = PIX_BRIGHT;
      else if (roll < bright_pct + 15) kind = PIX_EDGE;
      else if (roll < 60) kind = PIX_DARK;
      else kind = PIX_ANY;
      px     = make_pixel(kind);
      px.eor = (i == len - 1);
      // a stray start of frame inside a row now and then
      px.sof = (i == 0) ? sof_first : ($urandom_range(99, 0) == 0);
      pending_pixels.push_back(px);
    end
  endtask

  task automatic push_frame(int rows);
    bit sof_first;
    int len;
    sof_first = ($urandom_range(9, 0) != 0);
    for (int r = 0; r < rows; r++) begin
      len = ($urandom_range(99, 0) < 85) ? $urandom_range(16, 1) : $urandom_range(40, 17);
      push_row(len, $urandom_range(25, 0), (r == 0) && sof_first);
    end
  endtask

  task automatic random_traffic(int budget);
    while (pending_pixels.size() < budget) push_frame($urandom_range(12, 2));
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [COEF_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_taken);
  endtask

  task automatic configure(int c, int s, int m, int t);
    write_reg(CFG_COS_ANGLE, COEF_W'(c));
    write_reg(CFG_SIN_ANGLE, COEF_W'(s));
    write_reg(CFG_MIDDLE_COL, COEF_W'(m));
    write_reg(CFG_BRIGHT_THR, COEF_W'(t));
    cfg_valid <= 1'b0;
    gen_thr = t;
  endtask

  initial begin
    pixel_t px;
    reset_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < 9; phase++) begin
      in_idle_pct  = (phase < 3) ? 36 : ((phase < 6) ? 55 : 0);
      out_idle_pct = (phase < 3) ? 55 : ((phase < 6) ? 36 : 0);
      case (phase)
        0: begin
          // reset defaults: threshold edges, first hit wins, unsampled rows
          push_pixel(0, 0, 0, 0, 1);
          push_pixel(70, 71, 71, 0, 0);
          push_pixel(71, 70, 71, 0, 0);
          push_pixel(71, 71, 70, 0, 0);
          push_pixel(71, 71, 71, 0, 0);
          push_pixel(255, 255, 255, 1, 0);
          push_pixel(255, 255, 255, 1, 0);
          push_pixel(0, 0, 0, 1, 0);
          push_pixel(255, 0, 255, 1, 0);
          // sampled row without hit
          push_pixel(255, 255, 0, 0, 0);
          push_pixel(0, 255, 255, 1, 0);
          // one-pixel frame
          push_pixel(255, 255, 255, 1, 1);
          // restart in the middle of a row
          push_pixel(0, 0, 0, 0, 1);
          push_pixel(0, 0, 0, 0, 0);
          push_pixel(90, 90, 90, 0, 1);
          push_pixel(0, 0, 0, 1, 0);
          random_traffic(120);
        end
        1: begin
          configure(-32768, 32767, 2047, 0);
          random_traffic(150);
        end
        2: begin
          configure(32767, -32768, 0, 255);
          random_traffic(100);
        end
        3: begin
          configure($urandom_range(65535, 0), $urandom_range(65535, 0), 0, 100);
          random_traffic(150);
        end
        4: begin
          // back-to-back one-pixel rows
          configure($urandom_range(65535, 0), $urandom_range(65535, 0),
                    $urandom_range(2047, 0), $urandom_range(200, 0));
          for (int r = 0; r < 150; r++) begin
            px     = make_pixel(($urandom_range(1, 0) != 0) ? PIX_BRIGHT : PIX_ANY);
            px.eor = 1'b1;
            px.sof = (r == 0);
            pending_pixels.push_back(px);
          end
        end
        default: begin
          configure($urandom_range(65535, 0), $urandom_range(65535, 0),
                    $urandom_range(2047, 0), $urandom_range(180, 0));
          random_traffic(145);
        end
      endcase
      while (pending_pixels.size() != 0 || in_valid || expected_rows.size() != 0)
        @(negedge clk);
      repeat (DRAIN_CYCLES) @(negedge clk);
    end
    if (expected_rows.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_rows.size()));
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/llpe_pkg.sv
hw/rtl/laser_line_profile_extractor.sv
test/laser_line_profile_extractor_tb.sv
